### rtl/bashf_pkg.sv
// Shared types, constants and round functions for the bash-f permutation block.
// No dependencies.
package bashf_pkg;

  localparam int unsigned NumWords  = 24;
  localparam int unsigned NumRounds = 24;
  localparam int unsigned WordW     = 64;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned QueueDepth = 4;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] state_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } core_state_e;

  function automatic word_t round_const(input logic [IdxW-1:0] r);
    word_t c;
    c = '0;
    case (r)
      5'd0:  c = 64'h3BF5080AC8BA94B1;
      5'd1:  c = 64'hC1D1659C1BBD92F6;
      5'd2:  c = 64'h60E8B2CE0DDEC97B;
      5'd3:  c = 64'hEC5FB8FE790FBC13;
      5'd4:  c = 64'hAA043DE6436706A7;
      5'd5:  c = 64'h8929FF6A5E535BFD;
      5'd6:  c = 64'h98BF1E2C50C97550;
      5'd7:  c = 64'h4C5F8F162864BAA8;
      5'd8:  c = 64'h262FC78B14325D54;
      5'd9:  c = 64'h1317E3C58A192EAA;
      5'd10: c = 64'h098BF1E2C50C9755;
      5'd11: c = 64'hD8EE19681D669304;
      5'd12: c = 64'h6C770CB40EB34982;
      5'd13: c = 64'h363B865A0759A4C1;
      5'd14: c = 64'hC73622B47C4C0ACE;
      5'd15: c = 64'h639B115A3E260567;
      5'd16: c = 64'hEDE6693460F3DA1D;
      5'd17: c = 64'hAAD8D5034F9935A0;
      5'd18: c = 64'h556C6A81A7CC9AD0;
      5'd19: c = 64'h2AB63540D3E64D68;
      5'd20: c = 64'h155B1AA069F326B4;
      5'd21: c = 64'h0AAD8D5034F9935A;
      5'd22: c = 64'h0556C6A81A7CC9AD;
      5'd23: c = 64'hDE8082CD72DEBC78;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic word_t rotl(input word_t x, input int unsigned r);
    word_t y;
    y = (r == 0) ? x : ((x << r) | (x >> (WordW - r)));
    return y;
  endfunction

  // One full round: bash-S on all columns, word permutation P, constant into S23.
  function automatic state_t bash_round(input state_t s, input logic [IdxW-1:0] r);
    localparam int unsigned M1 [8] = '{8, 56, 8, 56, 8, 56, 8, 56};
    localparam int unsigned N1 [8] = '{53, 51, 37, 3, 21, 19, 5, 35};
    localparam int unsigned M2 [8] = '{14, 34, 46, 2, 14, 34, 46, 2};
    localparam int unsigned N2 [8] = '{1, 7, 49, 23, 33, 39, 17, 55};
    localparam int unsigned Src [24] = '{15, 10, 9, 12, 11, 14, 13, 8,
                                         17, 16, 19, 18, 21, 20, 23, 22,
                                         6, 3, 0, 5, 2, 7, 4, 1};
    state_t t;
    state_t o;
    word_t w0, w1, w2, z1, z2, u0, u1, u2;
    t = s;
    for (int j = 0; j < 8; j++) begin
      w0 = s[j];
      w1 = s[j+8];
      w2 = s[j+16];
      z2 = rotl(w0, M1[j]);
      u0 = w0 ^ w1 ^ w2;
      z1 = w1 ^ rotl(u0, N1[j]);
      u2 = w2 ^ rotl(w2, M2[j]) ^ rotl(z1, N2[j]);
      u1 = z1 ^ z2;
      t[j]    = u0 ^ (u1 | ~u2);
      t[j+8]  = u1 ^ (u0 | u2);
      t[j+16] = u2 ^ (u0 & u1);
    end
    for (int i = 0; i < 24; i++) begin
      o[i] = t[Src[i]];
    end
    o[23] = o[23] ^ round_const(r);
    return o;
  endfunction

endpackage

### rtl/bash_f_sponge_permutation_top.sv
// Top level of the bash-f (1536-bit) sponge permutation block.
// Depends on bashf_pkg, bashf_front and bashf_core.
//
// Push the state as 24 little-endian 64-bit words, S0 first. A small input
// queue absorbs words while the core is busy. Once S23 arrives the core runs
// the 24 rounds of bash-f, one round per clock in a single round unit, then
// presents S0..S23 of the permuted state on the result side; out_last_o marks
// S23. A block is loaded, permuted and emitted in turn; the core takes no new
// words until S23 of the last block is popped, since the single round unit and
// the single state register hold one block at a time.
module bash_f_sponge_permutation_top #(
  parameter int unsigned QueueDepth = bashf_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [63:0]  in_word_i,
  output logic         empty,
  input  logic         pop,
  output logic [63:0]  out_word_o,
  output logic         out_last_o
);
  logic             q_valid, q_take;
  bashf_pkg::word_t q_word;

  // front: buffer incoming beats
  bashf_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_word_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_word_o(q_word)
  );

  // back: load, permute, emit
  bashf_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take), .q_word_i(q_word),
    .empty_o(empty), .pop_i(pop), .out_word_o, .out_last_o
  );
endmodule

### rtl/bashf_front.sv
// Front end: takes input beats and feeds them into a short word queue.
// Depends on bashf_pkg.
module bashf_front #(
  parameter int unsigned Depth = bashf_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  bashf_pkg::word_t  in_word_i,
  output logic              q_valid_o,
  input  logic              q_take_i,
  output bashf_pkg::word_t  q_word_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  bashf_pkg::word_t mem_q [Depth];
  bashf_pkg::word_t head_q;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == (PtrW+1)'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_take_i && q_valid_o;
  assign q_word_o  = head_q;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  // Prefetch the next head word; bypass the beat being written into that slot.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= in_word_i;
    end
    head_q <= (do_push && (wr_q == rd_d)) ? in_word_i : mem_q[rd_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |=> !($past(do_pop))) else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
endmodule

### rtl/bashf_core.sv
// Back end: collects 24 words, runs 24 rounds one per cycle, emits 24 words.
// Depends on bashf_pkg.
module bashf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_take_o,
  input  bashf_pkg::word_t  q_word_i,
  output logic              empty_o,
  input  logic              pop_i,
  output bashf_pkg::word_t  out_word_o,
  output logic              out_last_o
);
  bashf_pkg::state_t      st_q, st_d;
  bashf_pkg::core_state_e fsm_q, fsm_d;
  logic [bashf_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic cnt_end;

  assign cnt_end    = (cnt_q == bashf_pkg::IdxW'(bashf_pkg::NumWords - 1));
  assign q_take_o   = (fsm_q == bashf_pkg::ST_LOAD) && q_valid_i;
  assign empty_o    = (fsm_q != bashf_pkg::ST_EMIT);
  assign out_word_o = st_q[0];
  assign out_last_o = cnt_end;

  always_comb begin
    st_d  = st_q;
    fsm_d = fsm_q;
    cnt_d = cnt_q;
    unique case (fsm_q)
      bashf_pkg::ST_LOAD: begin
        if (q_valid_i) begin
          // shift in at the top; after 24 beats S0 sits at index 0
          st_d = {q_word_i, st_q[bashf_pkg::NumWords-1:1]};
          cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
          if (cnt_end) fsm_d = bashf_pkg::ST_RUN;
        end
      end
      bashf_pkg::ST_RUN: begin
        st_d  = bashf_pkg::bash_round(st_q, cnt_q);
        cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
        if (cnt_end) fsm_d = bashf_pkg::ST_EMIT;
      end
      bashf_pkg::ST_EMIT: begin
        if (pop_i) begin
          st_d  = {st_q[0], st_q[bashf_pkg::NumWords-1:1]};
          cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
          if (cnt_end) fsm_d = bashf_pkg::ST_LOAD;
        end
      end
      default: fsm_d = bashf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= bashf_pkg::ST_LOAD;
      cnt_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      cnt_q <= cnt_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(fsm_q)) else $error("state not one-hot");
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == bashf_pkg::ST_RUN && cnt_end |=> fsm_q == bashf_pkg::ST_EMIT)
    else $error("rounds did not finish");
  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && pop_i && out_last_o |=> fsm_q == bashf_pkg::ST_LOAD)
    else $error("emit did not end on last word");
endmodule
